FILE: rtl/sbp_pkg.sv
// shared types, width-mode codes and lookup functions for the sub-byte item packer
`default_nettype none

package sbp_pkg;

   localparam int ModeW      = 3;
   localparam int WordW      = 24;
   localparam int StoreW     = 7;
   localparam int HeldW      = 3;
   localparam int SlotW      = 3;
   localparam int AccW       = StoreW + 8;
   localparam int CntW       = 2;

   localparam logic [ModeW-1:0] MODE_1BIT = 3'd0;
   localparam logic [ModeW-1:0] MODE_2BIT = 3'd1;
   localparam logic [ModeW-1:0] MODE_4BIT = 3'd2;
   localparam logic [ModeW-1:0] MODE_6BIT = 3'd3;
   localparam logic [ModeW-1:0] MODE_8BIT = 3'd4;

   typedef struct packed {
      logic [7:0] item_value;
      logic       end_of_data;
   } req_type;

   typedef struct packed {
      logic [7:0] packed_byte;
      logic       bad_item;
      logic       last_of_run;
   } rsp_type;

   // one classified request: bytes left-aligned in word, count of bytes to send
   typedef struct packed {
      logic [WordW-1:0] word;
      logic [CntW-1:0]  nbytes;
      logic             bad;
      logic             eod;
   } entry_type;

   function automatic logic [3:0] item_bits(input logic [ModeW-1:0] mode);
      logic [3:0] w;
      case (mode)
         MODE_1BIT: w = 4'd1;
         MODE_2BIT: w = 4'd2;
         MODE_4BIT: w = 4'd4;
         MODE_6BIT: w = 4'd6;
         default:   w = 4'd8;
      endcase
      return w;
   endfunction

   function automatic logic [SlotW:0] group_size(input logic [ModeW-1:0] mode);
      logic [SlotW:0] g;
      case (mode)
         MODE_1BIT: g = 4'd8;
         MODE_2BIT: g = 4'd4;
         MODE_4BIT: g = 4'd2;
         MODE_6BIT: g = 4'd4;
         default:   g = 4'd1;
      endcase
      return g;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/sbp_front.sv
// front end: accepts requests, packs bits and pushes classified queue entries
`default_nettype none

module sbp_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_we,
   input  wire logic [2:0]                csr_wdata,
   input  wire logic                      req_valid,
   output      logic                      req_ready,
   input  wire sbp_pkg::req_type          req_payload,
   input  wire logic                      q_full,
   output      logic                      q_push,
   output      sbp_pkg::entry_type        q_entry
);
   import sbp_pkg::*;

   logic [ModeW-1:0]  mode_ff, mode_in;
   logic [StoreW-1:0] store_ff, store_in;
   logic [HeldW-1:0]  held_ff, held_in;
   logic [SlotW-1:0]  slot_ff, slot_in;

   logic [3:0]        w;
   logic [SlotW:0]    gsize;
   logic              accept;
   logic              bad;
   logic [AccW-1:0]   acc;
   logic [3:0]        h;
   logic              full_byte;
   logic [4:0]        align;
   logic [WordW-1:0]  word;
   logic [CntW-1:0]   eod_bytes;
   logic [SlotW:0]    slot_inc;
   logic [HeldW-1:0]  held_after;

   assign w         = item_bits(mode_ff);
   assign gsize     = group_size(mode_ff);
   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign bad       = (req_payload.item_value >> w) != 8'd0;
   assign acc       = ({8'd0, store_ff} << w) | AccW'(req_payload.item_value);
   assign h         = 4'({1'b0, held_ff}) + w;
   assign full_byte = h >= 4'd8;
   assign align     = 5'(5'd24 - 5'(h));
   assign word      = {9'd0, acc} << align;
   assign slot_inc  = 4'({1'b0, slot_ff}) + 4'd1;
   assign held_after = full_byte ? 3'(h - 4'd8) : h[HeldW-1:0];

   always_comb begin
      eod_bytes = 2'd1;
      if (mode_ff == MODE_6BIT) begin
         case (slot_ff)
            3'd2:    eod_bytes = 2'd2;
            3'd3:    eod_bytes = 2'd1;
            default: eod_bytes = 2'd3;
         endcase
      end
   end

   always_comb begin
      q_push          = 1'b0;
      q_entry.word    = word;
      q_entry.nbytes  = req_payload.end_of_data ? eod_bytes : 2'd1;
      q_entry.bad     = 1'b0;
      q_entry.eod     = req_payload.end_of_data;
      mode_in         = mode_ff;
      store_in        = store_ff;
      held_in         = held_ff;
      slot_in         = slot_ff;
      if (csr_we) begin
         mode_in  = csr_wdata;
         store_in = '0;
         held_in  = '0;
         slot_in  = '0;
      end else if (accept) begin
         if (bad) begin
            q_push         = 1'b1;
            q_entry.word   = '0;
            q_entry.nbytes = 2'd1;
            q_entry.bad    = 1'b1;
            q_entry.eod    = 1'b0;
         end else if (req_payload.end_of_data) begin
            q_push   = 1'b1;
            store_in = '0;
            held_in  = '0;
            slot_in  = '0;
         end else begin
            q_push   = full_byte;
            held_in  = held_after;
            store_in = acc[StoreW-1:0] & ~(7'h7F << held_after);
            slot_in  = (slot_inc == gsize) ? '0 : slot_inc[SlotW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_8BIT;
         store_ff <= '0;
         held_ff  <= '0;
         slot_ff  <= '0;
      end else begin
         mode_ff  <= mode_in;
         store_ff <= store_in;
         held_ff  <= held_in;
         slot_ff  <= slot_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/sbp_queue.sv
// two-entry queue between the front and back ends
`default_nettype none

module sbp_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire sbp_pkg::entry_type  push_entry,
   input  wire logic                pop,
   output      sbp_pkg::entry_type  head,
   output      logic                empty,
   output      logic                full
);
   import sbp_pkg::*;

   entry_type  mem [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign empty = count_ff == 2'd0;
   assign full  = count_ff == 2'd2;
   assign head  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/sbp_back.sv
// back end: sends the bytes of each queue entry through the response register
`default_nettype none

module sbp_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire sbp_pkg::entry_type  head,
   input  wire logic                empty,
   output      logic                pop,
   output      logic                rsp_valid,
   input  wire logic                rsp_ready,
   output      sbp_pkg::rsp_type    rsp_payload
);
   import sbp_pkg::*;

   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_ff, rsp_in;
   logic [CntW-1:0] idx_ff, idx_in;
   logic            load;
   logic            final_byte;
   logic [7:0]      sel_byte;

   assign load       = !empty && (!rsp_valid_ff || rsp_ready);
   assign final_byte = (idx_ff + 2'd1) == head.nbytes;
   assign pop        = load && final_byte;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      case (idx_ff)
         2'd0:    sel_byte = head.word[23:16];
         2'd1:    sel_byte = head.word[15:8];
         default: sel_byte = head.word[7:0];
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      idx_in       = idx_ff;
      if (load) begin
         rsp_valid_in       = 1'b1;
         rsp_in.packed_byte = head.bad ? 8'd0 : sel_byte;
         rsp_in.bad_item    = head.bad;
         rsp_in.last_of_run = head.eod && final_byte;
         idx_in             = final_byte ? '0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      !empty |-> idx_ff < head.nbytes)
      else $error("byte index beyond entry");

   a_bad_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.bad_item |-> rsp_ff.packed_byte == 8'd0 && !rsp_ff.last_of_run)
      else $error("error response carries data");

   a_idx_reset_on_pop: assert property (@(posedge clock) disable iff (reset)
      pop |=> idx_ff == 2'd0)
      else $error("byte index not cleared after pop");

endmodule

`default_nettype wire

FILE: rtl/subbyte_item_packer_unit.sv
// top level of the sub-byte item packer
//
// packs 1, 2, 4, 6 or 8-bit items msb first into bytes
// req channel: valid/ready, one item and an end-of-data mark per request
// rsp channel: valid/ready, one packed byte with error and last flags per beat
// csr port: csr_we writes the 3-bit width mode; the user must write it only while
// the block is idle; the block itself does not enforce this
// the front end packs one request a cycle into the two-entry queue unless it is full
// the back end sends one byte a cycle from the queue into the response register
// while the response register is free or rsp_ready is high
// throughput: one request a cycle while requests give at most one byte each and
// rsp_ready stays high; an end-of-data request in 6-bit mode may give up to 3 bytes
// a request with an out-of-range item yields one error beat and changes nothing
// reset: width mode 8 bits, packing state and queue empty, no response valid
// receiver stall: the response register holds, the queue fills, then req_ready drops
`default_nettype none

module subbyte_item_packer_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_we,
   input  wire logic [2:0]        csr_wdata,
   input  wire logic              req_valid,
   output      logic              req_ready,
   input  wire sbp_pkg::req_type  req_payload,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      sbp_pkg::rsp_type  rsp_payload
);
   import sbp_pkg::*;

   entry_type push_entry;
   entry_type head;
   logic      push;
   logic      pop;
   logic      empty;
   logic      full;

   sbp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .q_full      (full),
      .q_push      (push),
      .q_entry     (push_entry)
   );

   sbp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .empty      (empty),
      .full       (full)
   );

   sbp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .empty       (empty),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

FILE: tb/tb_subbyte_item_packer_unit.sv
// self-checking testbench for the sub-byte item packer: directed table, then random requests
`timescale 1ns / 100ps

module tb_subbyte_item_packer_unit;
   import sbp_pkg::*;

   localparam int ClockPeriod = 10;
   localparam int CycleLimit  = 200000;
   localparam int SettleWait  = 8;
   localparam int BlockItems  = 25;

   // mode codes above the 8-bit code behave as 8 bits
   localparam logic [ModeW-1:0] MODE_WIDE5 = 3'd5;
   localparam logic [ModeW-1:0] MODE_WIDE6 = 3'd6;
   localparam logic [ModeW-1:0] MODE_WIDE7 = 3'd7;

   typedef struct packed {
      logic [ModeW-1:0] mode;
      logic [7:0]       value;
      logic             eod;
      logic             typed;
      rsp_type          want;
   } step_type;

   logic             clock;
   logic             reset       = 1'b1;
   logic             csr_we      = 1'b0;
   logic [2:0]       csr_wdata   = '0;
   logic             req_valid   = 1'b0;
   logic             req_ready;
   req_type          req_payload = '0;
   logic             rsp_valid;
   logic             rsp_ready   = 1'b0;
   rsp_type          rsp_payload;

   // predictor state
   logic [ModeW-1:0] width_mode  = MODE_8BIT;
   logic [15:0]      bit_store   = '0;
   int               bits_held   = 0;
   int               group_slot  = 0;

   rsp_type          pending_bytes [$];
   rsp_type          fresh_bytes [$];
   int               mismatches  = 0;
   int               cycle_count = 0;
   int               idle_phase  = 0;

   step_type directed_steps [25] = '{
      '{MODE_8BIT, 8'hA5, 1'b0, 1'b1, '{8'hA5, 1'b0, 1'b0}},
      '{MODE_8BIT, 8'h00, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{MODE_8BIT, 8'hFF, 1'b1, 1'b1, '{8'hFF, 1'b0, 1'b1}},
      '{MODE_1BIT, 8'h01, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{MODE_1BIT, 8'h00, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{MODE_1BIT, 8'h01, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{MODE_1BIT, 8'h02, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b0}},
      '{MODE_1BIT, 8'h01, 1'b1, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{MODE_1BIT, 8'h80, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b0}},
      '{MODE_1BIT, 8'h01, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{MODE_2BIT, 8'h03, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{MODE_2BIT, 8'h04, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b0}},
      '{MODE_2BIT, 8'h02, 1'b1, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{MODE_4BIT, 8'h0F, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{MODE_4BIT, 8'h10, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b0}},
      '{MODE_4BIT, 8'h00, 1'b1, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{MODE_6BIT, 8'h3F, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{MODE_6BIT, 8'h40, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b0}},
      '{MODE_6BIT, 8'h00, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{MODE_6BIT, 8'h2A, 1'b1, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{MODE_6BIT, 8'h3F, 1'b1, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{MODE_WIDE7, 8'hFF, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{MODE_WIDE7, 8'h00, 1'b1, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{MODE_WIDE5, 8'h80, 1'b1, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{MODE_8BIT, 8'h00, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1}}
   };

   logic [ModeW-1:0] mode_order [8] = '{
      MODE_1BIT, MODE_WIDE7, MODE_6BIT, MODE_2BIT,
      MODE_WIDE6, MODE_4BIT, MODE_WIDE5, MODE_8BIT
   };

   subbyte_item_packer_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #(ClockPeriod / 2) clock = ~clock;
   end

   function automatic int item_width(logic [ModeW-1:0] mode);
      case (mode)
         MODE_1BIT: return 1;
         MODE_2BIT: return 2;
         MODE_4BIT: return 4;
         MODE_6BIT: return 6;
         default:   return 8;
      endcase
   endfunction

   function automatic rsp_type make_rsp(logic [7:0] value, logic bad, logic last);
      rsp_type r;
      r.packed_byte = value;
      r.bad_item    = bad;
      r.last_of_run = last;
      return r;
   endfunction

   task automatic shift_in(int value, int w, int glen);
      int          held;
      int          sh;
      logic [15:0] chunk;
      bit_store = (bit_store << w) | 16'(value);
      held = bits_held + w;
      while (held >= 8) begin
         sh = held - 8;
         chunk = bit_store >> sh;
         fresh_bytes = {fresh_bytes, make_rsp(chunk[7:0], 1'b0, 1'b0)};
         held = sh;
         bit_store = bit_store & ((16'd1 << sh) - 16'd1);
      end
      bits_held = held;
      group_slot = (group_slot + 1 >= glen) ? 0 : group_slot + 1;
   endtask

   // works out the bytes one request produces and advances the packing state
   task automatic pack_item(req_type r);
      int          w;
      int          glen;
      int          guard;
      logic [15:0] aligned;
      fresh_bytes.delete();
      w = item_width(width_mode);
      case (width_mode)
         MODE_1BIT: glen = 8;
         MODE_2BIT: glen = 4;
         MODE_4BIT: glen = 2;
         MODE_6BIT: glen = 4;
         default:   glen = 1;
      endcase
      if (int'(r.item_value) > (1 << w) - 1) begin
         fresh_bytes = {fresh_bytes, make_rsp(8'h00, 1'b1, 1'b0)};
         return;
      end
      shift_in(int'(r.item_value), w, glen);
      if (r.end_of_data) begin
         guard = 0;
         while (group_slot != 0 && guard < 8) begin
            shift_in(0, w, glen);
            guard++;
         end
         if (bits_held != 0) begin
            aligned = bit_store << (8 - bits_held);
            fresh_bytes = {fresh_bytes, make_rsp(aligned[7:0], 1'b0, 1'b0)};
         end
         bit_store = '0;
         bits_held = 0;
         group_slot = 0;
         if (fresh_bytes.size() > 0) begin
            fresh_bytes[fresh_bytes.size() - 1].last_of_run = 1'b1;
         end
      end
   endtask

   task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
      $display("cycle %0d: %s mismatch, got %0h expected %0h", cycle_count, what, got, want);
      mismatches++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (SettleWait) @(posedge clock);
   endtask

   task automatic write_width(logic [ModeW-1:0] mode);
      drain();
      csr_we <= 1'b1;
      csr_wdata <= mode;
      @(posedge clock);
      csr_we <= 1'b0;
      width_mode = mode;
      bit_store = '0;
      bits_held = 0;
      group_slot = 0;
   endtask

   task automatic send_req(req_type r, logic typed, rsp_type want);
      int pct;
      pct = (idle_phase == 1) ? 74 : (idle_phase == 3) ? 27 : 0;
      while ($urandom_range(0, 99) < pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (req_ready !== 1'b1);
      pack_item(r);
      if (typed) begin
         pending_bytes = {pending_bytes, want};
      end else begin
         pending_bytes = {pending_bytes, fresh_bytes};
      end
   endtask

   // response checker and receiver stalls
   always @(posedge clock) begin
      rsp_type want;
      int      pct;
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Some tests failed");
         $finish;
      end else begin
         if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
            if (pending_bytes.size() == 0) begin
               report_mismatch("unexpected byte", rsp_payload.packed_byte, 8'h00);
            end else begin
               want = pending_bytes.pop_front();
               if (rsp_payload.packed_byte !== want.packed_byte)
                  report_mismatch("packed_byte", rsp_payload.packed_byte, want.packed_byte);
               if (rsp_payload.bad_item !== want.bad_item)
                  report_mismatch("bad_item", 8'(rsp_payload.bad_item), 8'(want.bad_item));
               if (rsp_payload.last_of_run !== want.last_of_run)
                  report_mismatch("last_of_run", 8'(rsp_payload.last_of_run),
                                  8'(want.last_of_run));
            end
         end
         pct = (idle_phase == 2) ? 74 : (idle_phase == 3) ? 27 : 0;
         rsp_ready <= ($urandom_range(0, 99) >= pct);
      end
   end

   initial begin
      req_type r;
      int      limit;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      idle_phase = 0;
      foreach (directed_steps[i]) begin
         if (directed_steps[i].mode != width_mode) write_width(directed_steps[i].mode);
         r.item_value = directed_steps[i].value;
         r.end_of_data = directed_steps[i].eod;
         send_req(r, directed_steps[i].typed, directed_steps[i].want);
      end

      for (int blk = 0; blk < 8; blk++) begin
         idle_phase = blk % 4;
         write_width(mode_order[blk]);
         limit = (1 << item_width(width_mode)) - 1;
         for (int n = 0; n < BlockItems; n++) begin
            // hold requests back until the block has delivered everything
            if (blk == 1 && n == BlockItems / 2) drain();
            if ($urandom_range(0, 99) < 12 && limit < 255)
               r.item_value = 8'($urandom_range(limit + 1, 255));
            else if ($urandom_range(0, 99) < 12)
               r.item_value = 8'($urandom_range(0, 255));
            else
               r.item_value = 8'($urandom_range(0, limit));
            r.end_of_data = ($urandom_range(0, 9) == 0);
            send_req(r, 1'b0, '0);
         end
      end

      drain();
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
